### hw/rtl/assert_macros.svh
// Assertion macros used by the controller of the waypoint advance block.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### hw/rtl/fswa_pkg.sv
// Package for the fixed-step waypoint advance block: widths, register
// indexes, controller states and the command/status structs. No dependencies.
`default_nettype none
package fswa_pkg;
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIST_W    = 20;
	localparam int FIT_W     = 31;
	localparam int SQ_W      = 2 * FIT_W + 1;
	localparam int ROOT_STEPS = (SQ_W + 1) / 2;
	localparam int ROOT_IDX_W = $clog2(ROOT_STEPS);
	localparam int D_W       = ROOT_STEPS;
	localparam int NUM_W     = FIT_W + DIST_W + 1;
	localparam int M_W       = DIST_W + 2;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int REG_IDX_W = 2;

	localparam logic [DIST_W-1:0] STEP_RESET =
		DIST_W'((((64'd1) << FRAC_BITS) * 2 + 5) / 10);
	localparam logic [DIST_W-1:0] RADIUS_RESET =
		DIST_W'((((64'd1) << FRAC_BITS) + 5) / 10);

	localparam logic [REG_IDX_W-1:0] REG_TARGET_X       = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_Y       = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_LENGTH    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ARRIVAL_RADIUS = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   diff_t;
	typedef logic        [COORD_W:0]   mag_t;
	typedef logic        [DIST_W-1:0]  dist_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_LOAD, CMD_TDIFF, CMD_ABS, CMD_SQX, CMD_SQY, CMD_SUM_R,
		CMD_RSTEP
	} cmd_a_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_TDIFF, OP_ABS, OP_SQX, OP_SQY, OP_SUM_R, OP_RSTEP,
		OP_SHIFT, OP_ROOT_INIT, OP_ROOT, OP_MULS, OP_NUM, OP_DIV, OP_APPLY,
		OP_COPY, OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_W_ABS, S_W_SQX, S_W_SQY, S_W_SUM, S_W_CMP,
		S_T_DIFF, S_T_ABS, S_T_SQX, S_T_SQY, S_T_SUM, S_T_CMPA, S_T_RSTEP,
		S_T_CMPS, S_COPY, S_SHIFT, S_E_SQX, S_E_SQY, S_E_SUM, S_ROOT_INIT,
		S_ROOT, S_MULS, S_NUM, S_DIV, S_APPLY, S_EMIT
	} state_t;

	typedef struct packed {
		op_t              op;
		logic             axis;
		logic [CNT_W-1:0] idx;
		logic             publish;
		logic             arrived;
	} cmd_t;

	typedef struct packed {
		logic lt;
		logic gt;
		logic wide;
	} status_t;
endpackage
`default_nettype wire

### hw/rtl/fswa_if.sv
// Valid/ready channel interfaces for position words in and waypoint words out.
// Depends on fswa_pkg.
`default_nettype none
interface fswa_pos_if;
	import fswa_pkg::*;
	logic   valid;
	logic   ready;
	coord_t position_x;
	coord_t position_y;
	modport source(output valid, position_x, position_y, input ready);
	modport sink(input valid, position_x, position_y, output ready);
endinterface

interface fswa_wp_if;
	import fswa_pkg::*;
	logic   valid;
	logic   ready;
	logic   publish;
	coord_t waypoint_east;
	coord_t waypoint_north;
	logic   arrived;
	modport source(output valid, publish, waypoint_east, waypoint_north, arrived, input ready);
	modport sink(input valid, publish, waypoint_east, waypoint_north, arrived, output ready);
endinterface
`default_nettype wire

### hw/rtl/fixed_step_waypoint_advance.sv
// Top level of the fixed-step waypoint advance block: controller plus datapath.
// Depends on fswa_pkg, fswa_if, fswa_ctrl and fswa_dp.
//
// Channel    Dir  Handshake     Word
// position   in   valid/ready   position_x, position_y (signed Q16.16)
// waypoint   out  valid/ready   publish, waypoint_east, waypoint_north, arrived
// cfg        in   cfg_we        cfg_index, cfg_data (no read-back)
//
// A tick that finds the robot not near the waypoint emits an unpublished word;
// else it marks arrival within the arrival radius, copies the target when it
// lies within one step, or shifts the offset into range, takes a square root
// and runs two serial divides through one multiplier. One tick is in flight at
// a time; the result register lets a new position be taken while the last
// waypoint word waits, and the next tick holds in its emit state until it goes.
// Reset is asynchronous; no clearing pass is needed.
`default_nettype none
module fixed_step_waypoint_advance (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	fswa_pos_if.sink                            position,
	fswa_wp_if.source                           waypoint,
	input  wire logic                           cfg_we,
	input  wire logic [fswa_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [fswa_pkg::COORD_W-1:0]   cfg_data
);
	import fswa_pkg::*;

	cmd_t    cmd;
	status_t status;

	fswa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (position.valid),
		.in_ready  (position.ready),
		.out_valid (waypoint.valid),
		.out_ready (waypoint.ready),
		.status    (status),
		.cmd       (cmd)
	);

	fswa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.pos_x       (position.position_x),
		.pos_y       (position.position_y),
		.out_publish (waypoint.publish),
		.out_east    (waypoint.waypoint_east),
		.out_north   (waypoint.waypoint_north),
		.out_arrived (waypoint.arrived)
	);
endmodule
`default_nettype wire

### hw/rtl/fswa_dp.sv
// Datapath: configuration registers, waypoint state, shared multiplier,
// bit-serial square root and restoring divider. Depends on fswa_pkg.
`default_nettype none
module fswa_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [fswa_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [fswa_pkg::COORD_W-1:0] cfg_data,
	input  wire fswa_pkg::cmd_t              cmd,
	output fswa_pkg::status_t                status,
	input  wire fswa_pkg::coord_t            pos_x,
	input  wire fswa_pkg::coord_t            pos_y,
	output logic                             out_publish,
	output fswa_pkg::coord_t                 out_east,
	output fswa_pkg::coord_t                 out_north,
	output logic                             out_arrived
);
	import fswa_pkg::*;

	coord_t target_x_q, target_y_q, next_east_q, next_north_q, px_q, py_q;
	dist_t  step_q, radius_q;
	diff_t  dx_q, dy_q;
	mag_t   ax_q, ay_q;
	logic   sx_q, sy_q;
	logic [SQ_W-1:0]   acc_q, rr_q, prod_q, root_q;
	logic [D_W-1:0]    d_q;
	logic [NUM_W-1:0]  num_q;
	logic [D_W-1:0]    rem_q;

	logic [FIT_W-1:0]   mul_a, mul_b;
	logic [2*FIT_W-1:0] mul_p;
	logic [SQ_W-1:0]    root_bit, root_try;
	logic [D_W:0]       rem_sh;
	logic               rem_ge;
	logic [M_W-1:0]     m_val;
	logic signed [COORD_W+1:0] app_sum;
	coord_t             app_sat, app_pos;
	logic               app_neg;
	logic               far;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			step_q     <= STEP_RESET;
			radius_q   <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_X:       target_x_q <= cfg_data;
				REG_TARGET_Y:       target_y_q <= cfg_data;
				REG_STEP_LENGTH:    step_q     <= cfg_data[DIST_W-1:0];
				REG_ARRIVAL_RADIUS: radius_q   <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = ax_q[FIT_W-1:0];
		mul_b = ax_q[FIT_W-1:0];
		case (cmd.op)
			OP_SQY: begin
				mul_a = ay_q[FIT_W-1:0];
				mul_b = ay_q[FIT_W-1:0];
			end
			OP_SUM_R: begin
				mul_a = FIT_W'(radius_q);
				mul_b = FIT_W'(radius_q);
			end
			OP_RSTEP: begin
				mul_a = FIT_W'(step_q);
				mul_b = FIT_W'(step_q);
			end
			OP_MULS: begin
				mul_a = cmd.axis ? ay_q[FIT_W-1:0] : ax_q[FIT_W-1:0];
				mul_b = FIT_W'(step_q);
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Square root and divider step terms
	assign root_bit = SQ_W'(1) << {cmd.idx[ROOT_IDX_W-1:0], 1'b0};
	assign root_try = root_q + root_bit;
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, d_q};

	// Offset and saturated waypoint for the selected axis
	assign m_val   = num_q[M_W-1:0];
	assign app_neg = cmd.axis ? sy_q : sx_q;
	assign app_pos = cmd.axis ? py_q : px_q;
	assign app_sum = (COORD_W+2)'(app_pos) +
		(app_neg ? -(COORD_W+2)'(m_val) : (COORD_W+2)'(m_val));
	always_comb begin
		if (app_sum > $signed((COORD_W+2)'({1'b0, {(COORD_W-1){1'b1}}})))
			app_sat = {1'b0, {(COORD_W-1){1'b1}}};
		else if (app_sum < -$signed((COORD_W+2)'({1'b1, {(COORD_W-1){1'b0}}})))
			app_sat = {1'b1, {(COORD_W-1){1'b0}}};
		else
			app_sat = app_sum[COORD_W-1:0];
	end

	// Main datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				px_q <= pos_x;
				py_q <= pos_y;
				dx_q <= (COORD_W+1)'(next_east_q) - (COORD_W+1)'(pos_x);
				dy_q <= (COORD_W+1)'(next_north_q) - (COORD_W+1)'(pos_y);
			end
			OP_TDIFF: begin
				dx_q <= (COORD_W+1)'(target_x_q) - (COORD_W+1)'(px_q);
				dy_q <= (COORD_W+1)'(target_y_q) - (COORD_W+1)'(py_q);
			end
			OP_ABS: begin
				ax_q <= dx_q[COORD_W] ? mag_t'(-dx_q) : mag_t'(dx_q);
				ay_q <= dy_q[COORD_W] ? mag_t'(-dy_q) : mag_t'(dy_q);
				sx_q <= dx_q[COORD_W];
				sy_q <= dy_q[COORD_W];
			end
			OP_SQX:   acc_q  <= SQ_W'(mul_p);
			OP_SQY:   prod_q <= SQ_W'(mul_p);
			OP_SUM_R: begin
				acc_q <= acc_q + prod_q;
				rr_q  <= SQ_W'(mul_p);
			end
			OP_RSTEP: rr_q <= SQ_W'(mul_p);
			OP_SHIFT: begin
				ax_q <= ax_q >> 1;
				ay_q <= ay_q >> 1;
			end
			OP_ROOT_INIT: root_q <= '0;
			OP_ROOT: begin
				if (acc_q >= root_try) begin
					acc_q  <= acc_q - root_try;
					root_q <= (root_q >> 1) + root_bit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			OP_MULS: begin
				prod_q <= SQ_W'(mul_p);
				d_q    <= (root_q == '0) ? D_W'(1) : root_q[D_W-1:0];
			end
			OP_NUM: begin
				num_q <= prod_q[NUM_W-1:0] + NUM_W'(d_q >> 1);
				rem_q <= '0;
			end
			OP_DIV: begin
				rem_q <= rem_ge ? D_W'(rem_sh - {1'b0, d_q}) : rem_sh[D_W-1:0];
				num_q <= {num_q[NUM_W-2:0], rem_ge};
			end
			default: ;
		endcase
	end

	// Waypoint state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_east_q  <= '0;
			next_north_q <= '0;
		end else if (cmd.op == OP_APPLY) begin
			if (cmd.axis)
				next_north_q <= app_sat;
			else
				next_east_q <= app_sat;
		end else if (cmd.op == OP_COPY) begin
			next_east_q  <= target_x_q;
			next_north_q <= target_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_publish <= cmd.publish;
			out_arrived <= cmd.arrived;
			out_east    <= next_east_q;
			out_north   <= next_north_q;
		end
	end

	// Status back to the controller
	assign far         = (|ax_q[COORD_W:DIST_W]) || (|ay_q[COORD_W:DIST_W]);
	assign status.lt   = !far && (acc_q < rr_q);
	assign status.gt   = far || (acc_q > rr_q);
	assign status.wide = (|ax_q[COORD_W:FIT_W]) || (|ay_q[COORD_W:FIT_W]);
endmodule
`default_nettype wire

### hw/rtl/fswa_ctrl.sv
// Controller: sequences the datapath per tick and owns the handshakes.
// Depends on fswa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fswa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire fswa_pkg::status_t status,
	output fswa_pkg::cmd_t     cmd
);
	import fswa_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             axis_q, axis_d, pub_q, pub_d, arr_q, arr_d, out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		axis_d  = axis_q;
		pub_d   = pub_q;
		arr_d   = arr_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_W_ABS;
			S_W_ABS:  state_d = S_W_SQX;
			S_W_SQX:  state_d = S_W_SQY;
			S_W_SQY:  state_d = S_W_SUM;
			S_W_SUM:  state_d = S_W_CMP;
			S_W_CMP: begin
				pub_d = 1'b0;
				arr_d = 1'b0;
				state_d = status.lt ? S_T_DIFF : S_EMIT;
			end
			S_T_DIFF: state_d = S_T_ABS;
			S_T_ABS:  state_d = S_T_SQX;
			S_T_SQX:  state_d = S_T_SQY;
			S_T_SQY:  state_d = S_T_SUM;
			S_T_SUM:  state_d = S_T_CMPA;
			S_T_CMPA: begin
				if (status.lt) begin
					arr_d   = 1'b1;
					state_d = S_EMIT;
				end else begin
					state_d = S_T_RSTEP;
				end
			end
			S_T_RSTEP: state_d = S_T_CMPS;
			S_T_CMPS:  state_d = status.gt ? S_SHIFT : S_COPY;
			S_COPY: begin
				pub_d   = 1'b1;
				state_d = S_EMIT;
			end
			S_SHIFT:     if (!status.wide) state_d = S_E_SQX;
			S_E_SQX:     state_d = S_E_SQY;
			S_E_SQY:     state_d = S_E_SUM;
			S_E_SUM:     state_d = S_ROOT_INIT;
			S_ROOT_INIT: begin
				cnt_d   = CNT_W'(ROOT_STEPS - 1);
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					axis_d  = 1'b0;
					state_d = S_MULS;
				end
			end
			S_MULS: state_d = S_NUM;
			S_NUM: begin
				cnt_d   = CNT_W'(NUM_W - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = S_APPLY;
			end
			S_APPLY: begin
				if (axis_q) begin
					pub_d   = 1'b1;
					state_d = S_EMIT;
				end else begin
					axis_d  = 1'b1;
					state_d = S_MULS;
				end
			end
			S_EMIT: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.axis    = axis_q;
		cmd.idx     = cnt_q;
		cmd.publish = pub_q;
		cmd.arrived = arr_q;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_W_ABS, S_T_ABS: cmd.op = OP_ABS;
			S_W_SQX, S_T_SQX, S_E_SQX: cmd.op = OP_SQX;
			S_W_SQY, S_T_SQY, S_E_SQY: cmd.op = OP_SQY;
			S_W_SUM, S_T_SUM, S_E_SUM: cmd.op = OP_SUM_R;
			S_T_DIFF:    cmd.op = OP_TDIFF;
			S_T_RSTEP:   cmd.op = OP_RSTEP;
			S_COPY:      cmd.op = OP_COPY;
			S_SHIFT:     if (status.wide) cmd.op = OP_SHIFT;
			S_ROOT_INIT: cmd.op = OP_ROOT_INIT;
			S_ROOT:      cmd.op = OP_ROOT;
			S_MULS:      cmd.op = OP_MULS;
			S_NUM:       cmd.op = OP_NUM;
			S_DIV:       cmd.op = OP_DIV;
			S_APPLY:     cmd.op = OP_APPLY;
			S_EMIT:      if (!out_valid_q || out_ready) cmd.op = OP_EMIT;
			default:     cmd.op = OP_NONE;
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			pub_q       <= 1'b0;
			arr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			pub_q   <= pub_d;
			arr_q   <= arr_d;
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_accept_starts, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_W_ABS), "accepted word did not start a tick")
	`ASSERT_NEVER(a_flags_excl, clk, arst_n, (cmd.op == OP_EMIT) && cmd.publish && cmd.arrived, "publish and arrived both set")
	`ASSERT_CLK(a_emit_valid, clk, arst_n, (cmd.op == OP_EMIT) |=> out_valid_q, "emitted word not presented")
endmodule
`default_nettype wire

### dv/tb_fixed_step_waypoint_advance.sv
// Self-checking testbench for the fixed-step waypoint advance block.
// Depends on fswa_pkg, fswa_if and the fixed_step_waypoint_advance RTL.
// A directed table, then random phases checked against an in-bench waypoint predictor.
`default_nettype none
module tb_fixed_step_waypoint_advance;
	timeunit 1ns;
	timeprecision 1ps;
	import fswa_pkg::*;

	localparam longint COORD_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN  = -64'sd2147483648;
	localparam int     DRAIN_CYC  = 220;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int     N_PHASES   = 20;
	localparam int     PHASE_WORDS = 100;

	typedef struct {
		logic   publish;
		coord_t east;
		coord_t north;
		logic   arrived;
	} waypoint_word_t;

	typedef enum {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [REG_IDX_W-1:0] idx;
		coord_t             a;      // position_x or register data
		coord_t             b;      // position_y
		bit                 typed;
		waypoint_word_t     want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	fswa_pos_if pos_ch();
	fswa_wp_if  wp_ch();

	fixed_step_waypoint_advance u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.position (pos_ch),
		.waypoint (wp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor copy of registers and waypoint
	longint          tgt_x, tgt_y, wp_e, wp_n;
	longint unsigned step_len, radius;

	waypoint_word_t pending_q[$];
	int     errors;
	int     words_sent;
	longint cycles;

	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("fixed_step_waypoint_advance test failed");
			$finish;
		end
	end

	function automatic longint clamp(longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	function automatic longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// sign of |(ax,ay)|^2 - r^2
	function automatic int len_vs(longint unsigned ax, longint unsigned ay,
			longint unsigned r);
		longint unsigned s, rr;
		if (ax >= (64'd1 << DIST_W) || ay >= (64'd1 << DIST_W)) return 1;
		s = ax * ax + ay * ay;
		rr = r * r;
		return s < rr ? -1 : (s > rr ? 1 : 0);
	endfunction

	function automatic longint step_offset(longint diff, longint unsigned e,
			longint unsigned d);
		longint unsigned m;
		m = (e * step_len + d / 2) / d;
		return diff < 0 ? -longint'(m) : longint'(m);
	endfunction

	// advance the waypoint for one tick and return the expected word
	function automatic waypoint_word_t advance_waypoint(coord_t px_c, coord_t py_c);
		waypoint_word_t w;
		longint px, py, dx, dy;
		longint unsigned ax, ay, ex, ey, d;
		int sh;
		px = px_c;
		py = py_c;
		w.publish = 0;
		w.arrived = 0;
		if (len_vs(absval(wp_e - px), absval(wp_n - py), radius) < 0) begin
			dx = tgt_x - px;
			dy = tgt_y - py;
			ax = absval(dx);
			ay = absval(dy);
			if (len_vs(ax, ay, radius) < 0) begin
				w.arrived = 1;
			end else begin
				if (len_vs(ax, ay, step_len) > 0) begin
					sh = 0;
					while ((ax >> sh) >= (64'd1 << FIT_W) || (ay >> sh) >= (64'd1 << FIT_W))
						sh++;
					ex = ax >> sh;
					ey = ay >> sh;
					d = root_floor(ex * ex + ey * ey);
					if (d == 0) d = 1;
					wp_e = clamp(px + step_offset(dx, ex, d));
					wp_n = clamp(py + step_offset(dy, ey, d));
				end else begin
					wp_e = tgt_x;
					wp_n = tgt_y;
				end
				w.publish = 1;
			end
		end
		w.east = coord_t'(wp_e);
		w.north = coord_t'(wp_n);
		return w;
	endfunction

	function automatic void note_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] v);
		case (idx)
			REG_TARGET_X:       tgt_x = coord_t'(v);
			REG_TARGET_Y:       tgt_y = coord_t'(v);
			REG_STEP_LENGTH:    step_len = v[DIST_W-1:0];
			REG_ARRIVAL_RADIUS: radius = v[DIST_W-1:0];
			default: ;
		endcase
	endfunction

	// sender: bursts of words with random gaps
	int burst_left;
	task automatic send_word(coord_t px, coord_t py);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				pos_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		pos_ch.valid <= 1'b1;
		pos_ch.position_x <= px;
		pos_ch.position_y <= py;
		@(posedge clk);
		while (!pos_ch.ready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic tick(coord_t px, coord_t py);
		pending_q.push_back(advance_waypoint(px, py));
		send_word(px, py);
	endtask

	// hold input until every waypoint word is back and the block is quiet
	task automatic drain();
		pos_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		note_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic set_regs(coord_t tx, coord_t ty, dist_t st, dist_t ra);
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_STEP_LENGTH, COORD_W'(st));
		write_reg(REG_ARRIVAL_RADIUS, COORD_W'(ra));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'(COORD_MAX);
			1: return coord_t'(COORD_MIN);
			2, 3: return coord_t'($urandom());
			default: return coord_t'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
		endcase
	endfunction

	function automatic dist_t pick_dist(bit allow_zero);
		case ($urandom_range(0, 7))
			0: return allow_zero ? dist_t'(0) : dist_t'(1);
			1: return dist_t'(655360);
			2: return dist_t'($urandom_range(1, 64));
			default: return dist_t'($urandom_range(1000, 655360));
		endcase
	endfunction

	function automatic coord_t jitter(longint centre);
		longint span;
		span = radius / 2;
		return coord_t'(clamp(centre + $signed($urandom_range(0, 2 * span)) - span));
	endfunction

	// receiver: stall pattern plus one long hold-off; check every word
	initial begin
		int mode, left, hold, pct;
		bit held;
		waypoint_word_t w;
		wp_ch.ready = 1'b0;
		left = 0;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (wp_ch.valid && wp_ch.ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected waypoint word pub=%0b e=%0d n=%0d arr=%0b",
						$realtime, wp_ch.publish, wp_ch.waypoint_east,
						wp_ch.waypoint_north, wp_ch.arrived);
					errors++;
				end else begin
					w = pending_q.pop_front();
					if (wp_ch.publish !== w.publish) begin
						$display("%0t: publish expected %0b actual %0b",
							$realtime, w.publish, wp_ch.publish);
						errors++;
					end
					if (wp_ch.waypoint_east !== w.east) begin
						$display("%0t: waypoint_east expected %0d actual %0d",
							$realtime, w.east, wp_ch.waypoint_east);
						errors++;
					end
					if (wp_ch.waypoint_north !== w.north) begin
						$display("%0t: waypoint_north expected %0d actual %0d",
							$realtime, w.north, wp_ch.waypoint_north);
						errors++;
					end
					if (wp_ch.arrived !== w.arrived) begin
						$display("%0t: arrived expected %0b actual %0b",
							$realtime, w.arrived, wp_ch.arrived);
						errors++;
					end
				end
			end
			// long hold-off once the random part is under way
			if (!held && words_sent >= 300) begin
				held = 1;
				hold = 3000;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 400);
			end
			left--;
			pct = (mode == 0) ? 100 : (mode == 1) ? 50 : (mode == 2) ? 15 : 90;
			if (hold > 0) begin
				hold--;
				wp_ch.ready <= 1'b0;
			end else begin
				wp_ch.ready <= ($urandom_range(1, 100) <= pct);
			end
		end
	end

	row_t plan[$];

	function automatic row_t word_row(coord_t x, coord_t y, bit typed, logic pub,
			coord_t e, coord_t n, logic arr);
		row_t r;
		r.kind = ROW_WORD;
		r.idx = REG_TARGET_X;
		r.a = x;
		r.b = y;
		r.typed = typed;
		r.want.publish = pub;
		r.want.east = e;
		r.want.north = n;
		r.want.arrived = arr;
		return r;
	endfunction

	function automatic row_t reg_row(logic [REG_IDX_W-1:0] idx, coord_t v);
		row_t r;
		r = word_row(v, 0, 0, 0, 0, 0, 0);
		r.kind = ROW_REG;
		r.idx = idx;
		return r;
	endfunction

	initial begin
		waypoint_word_t w;
		coord_t px, py;
		int sel;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TARGET_X;
		cfg_data = '0;
		pos_ch.valid = 1'b0;
		pos_ch.position_x = '0;
		pos_ch.position_y = '0;
		errors = 0;
		words_sent = 0;
		cycles = 0;
		burst_left = 0;
		tgt_x = 0;
		tgt_y = 0;
		wp_e = 0;
		wp_n = 0;
		step_len = STEP_RESET;
		radius = RADIUS_RESET;

		// directed table: reset values, extremes, short steps, zero step/radius
		plan.push_back(word_row(0, 0, 1, 0, 0, 0, 1));
		plan.push_back(word_row(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 1, 0, 0, 0, 0));
		plan.push_back(word_row(coord_t'(COORD_MIN), coord_t'(COORD_MIN), 1, 0, 0, 0, 0));
		plan.push_back(word_row(coord_t'(COORD_MIN), coord_t'(COORD_MAX), 1, 0, 0, 0, 0));
		plan.push_back(word_row(6553, 0, 1, 0, 0, 0, 1));
		plan.push_back(word_row(6554, 0, 1, 0, 0, 0, 0));
		plan.push_back(reg_row(REG_TARGET_X, 65536));
		plan.push_back(word_row(0, 0, 1, 1, 13107, 0, 0));
		plan.push_back(word_row(13107, 0, 1, 1, 26214, 0, 0));
		plan.push_back(reg_row(REG_STEP_LENGTH, 0));
		plan.push_back(word_row(26214, 0, 1, 1, 26214, 0, 0));
		plan.push_back(reg_row(REG_STEP_LENGTH, 655360));
		plan.push_back(word_row(26214, 0, 1, 1, 65536, 0, 0));
		plan.push_back(word_row(65536, 0, 1, 0, 65536, 0, 1));
		plan.push_back(reg_row(REG_TARGET_X, coord_t'(COORD_MIN)));
		plan.push_back(reg_row(REG_TARGET_Y, coord_t'(COORD_MAX)));
		plan.push_back(word_row(65536, 100, 0, 0, 0, 0, 0));
		plan.push_back(reg_row(REG_ARRIVAL_RADIUS, 0));
		plan.push_back(word_row(65536, 0, 0, 0, 0, 0, 0));
		plan.push_back(reg_row(REG_ARRIVAL_RADIUS, 655360));
		plan.push_back(reg_row(REG_TARGET_X, coord_t'(COORD_MAX)));
		plan.push_back(word_row(0, 0, 0, 0, 0, 0, 0));
		plan.push_back(word_row(-5, 3, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				drain();
				write_reg(plan[i].idx, plan[i].a);
				cfg_we <= 1'b0;
				@(posedge clk);
			end else if (plan[i].typed) begin
				w = advance_waypoint(plan[i].a, plan[i].b);
				pending_q.push_back(plan[i].want);
				send_word(plan[i].a, plan[i].b);
			end else begin
				tick(plan[i].a, plan[i].b);
			end
		end

		// random phases: mostly chains that follow the waypoint
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			set_regs(pick_coord(), pick_coord(), pick_dist(1), pick_dist(ph % 7 == 3));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					px = jitter(wp_e);
					py = jitter(wp_n);
				end else if (sel < 88) begin
					px = jitter(tgt_x);
					py = jitter(tgt_y);
				end else if (sel < 95) begin
					px = coord_t'($urandom());
					py = coord_t'($urandom());
				end else begin
					px = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
					py = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
				end
				tick(px, py);
			end
		end

		drain();
		if (errors == 0) begin
			$display("fixed_step_waypoint_advance test passed");
		end else begin
			$display("fixed_step_waypoint_advance test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
